>>> src/ccmb_pkg.sv
// ----------------------------------------------------------------------------
// Coalescing command mailbox package
// Shared widths, codes, state encoding and the kind mask test.
// ----------------------------------------------------------------------------
package ccmb_pkg;

    localparam int KIND_W            = 4;
    localparam int KEY_W             = 64;
    localparam int PAYLOAD_W         = 64;
    localparam int STATUS_W          = 3;
    localparam int MASK_W            = 16;
    localparam int KIND_COUNT        = 16;
    localparam int MAILBOX_DEPTH_DEF = 64;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTED_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFECYCLE_MASK = 2'd1;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED   = 3'd0,
        ST_SUPERSEDED = 3'd1,
        ST_EVICTING   = 3'd2,
        ST_REJECTED   = 3'd3,
        ST_DROPPED    = 3'd4,
        ST_DRAINED    = 3'd5,
        ST_EMPTY      = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DRAIN,
        S_DRD,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic opcode;
        t_entry ent;
    } t_cmd;

    typedef struct packed {
        t_status status;
        t_entry  ent;
        logic    last;
    } t_res;

    typedef struct packed {
        logic hit;
        logic evictable;
    } t_match;

    function automatic logic kind_in_mask(input logic [MASK_W-1:0] mask,
                                          input logic [KIND_W-1:0] kind);
        logic below;
        below = ({1'b0, kind} < (KIND_W + 1)'(KIND_COUNT));
        return below && mask[kind];
    endfunction

endpackage

>>> src/ccmb_in_if.sv
// ----------------------------------------------------------------------------
// Mailbox command channel
// Valid/ready channel carrying one submit or drain beat.
// ----------------------------------------------------------------------------
interface ccmb_in_if;
    import ccmb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [KIND_W-1:0]    command_kind;
    logic [KEY_W-1:0]     command_key;
    logic [PAYLOAD_W-1:0] command_payload;

    modport source (
        output valid, opcode, command_kind, command_key, command_payload,
        input  ready
    );

    modport sink (
        input  valid, opcode, command_kind, command_key, command_payload,
        output ready
    );

endinterface

>>> src/ccmb_out_if.sv
// ----------------------------------------------------------------------------
// Mailbox result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface ccmb_out_if;
    import ccmb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [KIND_W-1:0]    entry_kind;
    logic [KEY_W-1:0]     entry_key;
    logic [PAYLOAD_W-1:0] entry_payload;
    logic                 last;

    modport source (
        output valid, status, entry_kind, entry_key, entry_payload, last,
        input  ready
    );

    modport sink (
        input  valid, status, entry_kind, entry_key, entry_payload, last,
        output ready
    );

endinterface

>>> src/ccmb_match.sv
// ----------------------------------------------------------------------------
// Mailbox entry compare unit
// Compares one stored entry with the pending command and tests evictability.
// ----------------------------------------------------------------------------
module ccmb_match (
    input  logic [ccmb_pkg::KIND_W-1:0] i_ent_kind,
    input  logic [ccmb_pkg::KEY_W-1:0]  i_ent_key,
    input  logic [ccmb_pkg::KIND_W-1:0] i_cmd_kind,
    input  logic [ccmb_pkg::KEY_W-1:0]  i_cmd_key,
    input  logic [ccmb_pkg::MASK_W-1:0] i_lc_mask,
    output ccmb_pkg::t_match            o_match
);
    import ccmb_pkg::*;

    always_comb begin
        o_match.hit       = (i_ent_kind == i_cmd_kind) && (i_ent_key == i_cmd_key);
        o_match.evictable = !kind_in_mask(i_lc_mask, i_ent_kind);
    end

endmodule

>>> src/coalescing_command_mailbox_core.sv
// ----------------------------------------------------------------------------
// Coalescing command mailbox core
// Bounded ordered command store with coalescing, eviction and drain.
// ----------------------------------------------------------------------------
// Commands arrive as beats on i_cmd and results leave as beats on o_res.
// A submit gives exactly one result beat. A drain gives one beat per pending
// entry in order, or one empty beat, with last set on the final beat.
// A submit scans the stored entries through one compare unit and one memory
// read port, one entry per cycle. An eviction adds a shift pass of one entry
// per cycle behind the victim. A drain reads each entry through the S_DRAIN,
// S_DRD and S_RESULT states in turn. i_cmd.ready is high only while no
// command is in progress; the final result sits in an output register, so
// the next command may be taken while that beat waits. A stalled receiver
// holds the block at its next result. Reset empties the mailbox and restores
// both kind masks; the store itself needs no clearing pass. The user must
// write the masks via i_cfg_* only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module coalescing_command_mailbox_core #(
    parameter int MAILBOX_DEPTH = ccmb_pkg::MAILBOX_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ccmb_in_if.sink                        i_cmd,
    ccmb_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [ccmb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ccmb_pkg::MASK_W-1:0]    i_cfg_wdata
);
    import ccmb_pkg::*;

    localparam int AW = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
    localparam int CW = $clog2(MAILBOX_DEPTH + 1);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [CW-1:0] r_occ, n_occ;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pidx, n_pidx;
    logic          r_ev_found, n_ev_found;
    logic [AW-1:0] r_ev_idx, n_ev_idx;
    t_entry        r_ev_ent, n_ev_ent;
    t_res          r_res, n_res;
    logic          r_more, n_more;
    t_res          r_out, n_out;
    logic          r_out_vld, n_out_vld;
    logic [MASK_W-1:0] r_acc_mask, r_lc_mask;

    t_entry        r_mem [MAILBOX_DEPTH];
    t_entry        r_rdata;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata;

    t_match  match;
    t_entry  cmd_ent;
    logic    accept, out_free, issue, hit, scan_done, not_full, cmd_lc;

    ccmb_match u_match (
        .i_ent_kind (r_rdata.kind),
        .i_ent_key  (r_rdata.key),
        .i_cmd_kind (r_cmd.ent.kind),
        .i_cmd_key  (r_cmd.ent.key),
        .i_lc_mask  (r_lc_mask),
        .o_match    (match)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_vld || o_res.ready;
    assign issue       = (r_idx < r_occ);
    assign hit         = r_pend && match.hit;
    assign scan_done   = !r_pend && !issue;
    assign not_full    = (r_occ < CW'(MAILBOX_DEPTH));
    assign cmd_lc      = kind_in_mask(r_lc_mask, r_cmd.ent.kind);

    assign cmd_ent.kind    = i_cmd.command_kind;
    assign cmd_ent.key     = i_cmd.command_key;
    assign cmd_ent.payload = i_cmd.command_payload;

    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_out.status;
    assign o_res.entry_kind    = r_out.ent.kind;
    assign o_res.entry_key     = r_out.ent.key;
    assign o_res.entry_payload = r_out.ent.payload;
    assign o_res.last          = r_out.last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == OP_DRAIN) begin
                        n_state = (r_occ == '0) ? S_RESULT : S_DRAIN;
                    end else if (!kind_in_mask(r_acc_mask, i_cmd.command_kind)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = S_RESULT;
                end else if (scan_done) begin
                    n_state = (!not_full && cmd_lc && r_ev_found) ? S_SHIFT : S_RESULT;
                end
            end
            S_SHIFT: begin
                if (!r_pend && !issue) begin
                    n_state = S_RESULT;
                end
            end
            S_DRAIN:  n_state = S_DRD;
            S_DRD:    n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_state = r_more ? S_DRAIN : S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_occ      = r_occ;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pidx     = r_idx[AW-1:0];
        n_ev_found = r_ev_found;
        n_ev_idx   = r_ev_idx;
        n_ev_ent   = r_ev_ent;
        n_res      = r_res;
        n_more     = r_more;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !o_res.ready;
        mem_we     = 1'b0;
        mem_waddr  = r_occ[AW-1:0];
        mem_wdata  = r_cmd.ent;
        mem_re     = 1'b0;
        mem_raddr  = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd.opcode = i_cmd.opcode;
                    n_cmd.ent    = cmd_ent;
                    n_idx        = '0;
                    n_ev_found   = 1'b0;
                    n_more       = 1'b0;
                    n_res        = '{status: ST_REJECTED, ent: '0, last: 1'b1};
                    if (i_cmd.opcode == OP_DRAIN) begin
                        n_res.status = ST_EMPTY;
                    end
                end
            end
            S_SCAN: begin
                mem_re = issue;
                n_pend = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend && !match.hit && !r_ev_found && match.evictable) begin
                    n_ev_found = 1'b1;
                    n_ev_idx   = r_pidx;
                    n_ev_ent   = r_rdata;
                end
                n_res = '{status: ST_DROPPED, ent: '0, last: 1'b1};
                if (hit) begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_pidx;
                    n_res.status = ST_SUPERSEDED;
                end else if (scan_done) begin
                    if (not_full) begin
                        mem_we       = 1'b1;
                        n_occ        = r_occ + CW'(1);
                        n_res.status = ST_ACCEPTED;
                    end else if (cmd_lc && r_ev_found) begin
                        n_idx = CW'(r_ev_idx) + CW'(1);
                    end
                end
            end
            S_SHIFT: begin
                mem_re = issue;
                n_pend = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pidx - AW'(1);
                    mem_wdata = r_rdata;
                end else if (!issue) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_occ - CW'(1));
                    n_res     = '{status: ST_EVICTING, ent: r_ev_ent, last: 1'b1};
                end
            end
            S_DRAIN: begin
                mem_re = 1'b1;
            end
            S_DRD: begin
                n_res.status = ST_DRAINED;
                n_res.ent    = r_rdata;
                n_res.last   = ((r_idx + CW'(1)) == r_occ);
                n_more       = !n_res.last;
                n_idx        = r_idx + CW'(1);
                if (n_res.last) begin
                    n_occ = '0;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_more = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_ev_found <= 1'b0;
            r_more     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_acc_mask <= '1;
            r_lc_mask  <= '0;
        end else begin
            r_state    <= n_state;
            r_occ      <= n_occ;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_ev_found <= n_ev_found;
            r_more     <= n_more;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACCEPTED_MASK:  r_acc_mask <= i_cfg_wdata;
                    CFG_LIFECYCLE_MASK: r_lc_mask  <= i_cfg_wdata;
                    default: begin
                        r_acc_mask <= r_acc_mask;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_pidx   <= n_pidx;
        r_ev_idx <= n_ev_idx;
        r_ev_ent <= n_ev_ent;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

>>> src/ccmb_checker.sv
// ----------------------------------------------------------------------------
// Coalescing command mailbox port checker
// Watches the ports of the mailbox core and flags illegal behavior.
// ----------------------------------------------------------------------------
module ccmb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [ccmb_pkg::STATUS_W-1:0]  i_status,
    input logic [ccmb_pkg::KIND_W-1:0]    i_kind,
    input logic [ccmb_pkg::KEY_W-1:0]     i_key,
    input logic [ccmb_pkg::PAYLOAD_W-1:0] i_payload,
    input logic                           i_last
);
    import ccmb_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("Command taken while a command was in progress.");

    a_last_on_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_DRAINED)) |-> i_last)
        else $error("Single result beat without last.");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_DRAINED) && (i_status != ST_EVICTING))
        |-> ((i_kind == '0) && (i_key == '0) && (i_payload == '0)))
        else $error("Entry fields set on a result that carries no entry.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("Result beat withdrawn before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        ($stable(i_status) && $stable(i_key) && $stable(i_payload) && $stable(i_last)))
        else $error("Stalled result beat changed.");

endmodule

bind coalescing_command_mailbox_core ccmb_checker u_ccmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_kind      (o_res.entry_kind),
    .i_key       (o_res.entry_key),
    .i_payload   (o_res.entry_payload),
    .i_last      (o_res.last)
);
